/* rtl/pntge_pkg.sv */
`timescale 1ns / 1ps
// Package for the Petri net token game engine: sizes, codes and shared types.
// Has no dependencies. Every module of the block imports it.
package pntge_pkg;

    localparam int NUM_ELEMENTS    = 64;
    localparam int NUM_TRANSITIONS = 32;
    localparam int NUM_PLACES      = 128;
    localparam int TOKEN_BITS      = 16;

    localparam int ELEM_W  = $clog2(NUM_ELEMENTS);
    localparam int TRANS_W = (NUM_TRANSITIONS > 1) ? $clog2(NUM_TRANSITIONS) : 1;
    localparam int CNT_W   = $clog2(NUM_TRANSITIONS + 1);
    localparam int PLACE_W = $clog2(NUM_PLACES);
    localparam int NSLOT   = 6;
    localparam int SLOT_W  = 3;
    localparam int RND_W   = 16;
    localparam int TC_W    = 16;

    localparam logic [TOKEN_BITS-1:0] TOKEN_MAX = {TOKEN_BITS{1'b1}};

    typedef enum logic [2:0] {
        OP_LOAD_ELEM = 3'd0,
        OP_LOAD_MARK = 3'd1,
        OP_ARRIVE    = 3'd2,
        OP_STEP      = 3'd3,
        OP_READ      = 3'd4
    } op_t;

    localparam logic [2:0] EK_PIPE = 3'd0;
    localparam logic [2:0] EK_SYNC = 3'd1;
    localparam logic [2:0] EK_PORT = 3'd4;

    typedef enum logic [1:0] {
        RK_ACK   = 2'd0,
        RK_SENT  = 2'd1,
        RK_FIRED = 2'd2,
        RK_NONE  = 2'd3
    } res_kind_t;

    // Slot 0 holds place_a, slot 5 holds place_f.
    typedef struct packed {
        logic [2:0]                     kind;
        logic [NSLOT-1:0][PLACE_W-1:0]  place;
    } entry_t;

    typedef struct packed {
        res_kind_t              kind;
        logic [6:0]             dest;
        logic                   dir;
        logic [5:0]             fired;
        logic [5:0]             count;
        logic [15:0]            value;
        logic                   last;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARR_WR,
        ST_READ_DONE,
        ST_P_ISSUE,
        ST_P_CHK,
        ST_P_TOK,
        ST_P_NEXT,
        ST_T_ISSUE,
        ST_T_CHK,
        ST_T_PL,
        ST_T_NEXT,
        ST_DIV,
        ST_F_ISSUE,
        ST_F_RD,
        ST_F_MOD,
        ST_EMIT
    } state_t;

endpackage

/* rtl/pntge_divider.sv */
`timescale 1ns / 1ps
// Restoring divider that gives random_value modulo the enabled count,
// one quotient bit per cycle. Depends on pntge_pkg.
module pntge_divider
    import pntge_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [RND_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [CNT_W-1:0] remainder
);

    localparam int ITER_W = $clog2(RND_W + 1);

    logic [RND_W-1:0]  num_reg;
    logic [CNT_W:0]    rem_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W:0]    trial;

    assign trial = {rem_reg[CNT_W-1:0], num_reg[RND_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                iter_reg <= ITER_W'(RND_W);
                num_reg  <= dividend;
                div_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                num_reg <= {num_reg[RND_W-2:0], 1'b0};
                if (trial >= {1'b0, div_reg}) begin
                    rem_reg <= trial - {1'b0, div_reg};
                end else begin
                    rem_reg <= trial;
                end
                iter_reg <= iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[CNT_W-1:0];

endmodule

/* rtl/pntge_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer with the netlist and place memories: loads, arrivals, reads and
// the step with its port, scan and firing phases. Depends on pntge_pkg and
// pntge_divider.
module pntge_ctrl
    import pntge_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         in_op,
    input  logic [ELEM_W-1:0]  in_index,
    input  logic [2:0]         in_kind,
    input  logic [NSLOT-1:0][PLACE_W-1:0] in_place,
    input  logic [TC_W-1:0]    in_tc,
    input  logic [RND_W-1:0]   in_rnd,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res
);

    entry_t nl_mem [NUM_ELEMENTS];
    logic [TOKEN_BITS-1:0] pl_mem [NUM_PLACES];
    logic [TRANS_W-1:0] en_list [NUM_TRANSITIONS];

    state_t state_reg, state_next;

    entry_t                nl_q;
    logic [TOKEN_BITS-1:0] p_q;
    logic [ELEM_W-1:0]     nl_raddr;
    logic                  nl_we;
    logic [PLACE_W-1:0]    p_raddr, p_waddr;
    logic                  p_we;
    logic [TOKEN_BITS-1:0] p_wdata;
    logic                  div_start, div_done;
    logic [CNT_W-1:0]      div_rem;

    logic [PLACE_W-1:0]    a_reg;
    logic [TC_W-1:0]       tc_reg;
    logic [RND_W-1:0]      rnd_reg;
    logic [ELEM_W-1:0]     e_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [ELEM_W-1:0]     pick_reg;
    entry_t                ent_reg;
    result_t               res_reg;

    logic                  accept;
    logic [SLOT_W-1:0]     n_in;
    logic [TC_W:0]         arr_sum;

    assign accept  = in_valid && in_ready;
    assign n_in    = (ent_reg.kind == EK_SYNC) ? SLOT_W'(3) : SLOT_W'(2);
    assign arr_sum = {1'b0, tc_reg} + (TC_W+1)'(p_q);

    pntge_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (rnd_reg),
        .divisor   (cnt_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Memories: one write and one registered read per cycle each.
    always_ff @(posedge aclk) begin
        if (nl_we) begin
            nl_mem[in_index] <= '{kind: in_kind, place: in_place};
        end
        nl_q <= nl_mem[nl_raddr];
        if (p_we) begin
            pl_mem[p_waddr] <= p_wdata;
        end
        p_q <= pl_mem[p_raddr];
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_op)
                        OP_ARRIVE: state_next = ST_ARR_WR;
                        OP_READ:   state_next = ST_READ_DONE;
                        OP_STEP:   state_next = ST_P_ISSUE;
                        default:   state_next = ST_EMIT;
                    endcase
                end
            end
            ST_ARR_WR:    state_next = ST_EMIT;
            ST_READ_DONE: state_next = ST_EMIT;
            ST_P_ISSUE:   state_next = ST_P_CHK;
            ST_P_CHK:     state_next = (nl_q.kind == EK_PORT) ? ST_P_TOK : ST_P_NEXT;
            ST_P_TOK:     state_next = (p_q != '0) ? ST_EMIT : ST_P_NEXT;
            ST_P_NEXT: begin
                state_next = (e_reg == ELEM_W'(NUM_ELEMENTS - 1)) ? ST_T_ISSUE : ST_P_ISSUE;
            end
            ST_T_ISSUE: state_next = ST_T_CHK;
            ST_T_CHK: begin
                state_next = (nl_q.kind == EK_PIPE || nl_q.kind == EK_SYNC) ?
                             ST_T_PL : ST_T_NEXT;
            end
            ST_T_PL: begin
                if (p_q == '0 || slot_reg == n_in - 1'b1) begin
                    state_next = ST_T_NEXT;
                end
            end
            ST_T_NEXT: begin
                if (e_reg == ELEM_W'(NUM_TRANSITIONS - 1)) begin
                    state_next = (cnt_reg == '0) ? ST_EMIT : ST_DIV;
                end else begin
                    state_next = ST_T_ISSUE;
                end
            end
            ST_DIV:     state_next = div_done ? ST_F_ISSUE : ST_DIV;
            ST_F_ISSUE: state_next = ST_F_RD;
            ST_F_RD:    state_next = ST_F_MOD;
            ST_F_MOD: begin
                state_next = (slot_reg == n_in + n_in - 1'b1) ? ST_EMIT : ST_F_RD;
            end
            ST_EMIT: begin
                if (res_ready) begin
                    state_next = res_reg.last ? ST_IDLE : ST_P_NEXT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and memory controls.
    always_comb begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        div_start = 1'b0;
        nl_we     = 1'b0;
        nl_raddr  = e_reg;
        p_we      = 1'b0;
        p_raddr   = in_place[0];
        p_waddr   = in_place[0];
        p_wdata   = (in_tc > TC_W'(TOKEN_MAX)) ? TOKEN_MAX : in_tc[TOKEN_BITS-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                nl_we    = accept && (in_op == OP_LOAD_ELEM);
                p_we     = accept && (in_op == OP_LOAD_MARK);
            end
            ST_ARR_WR: begin
                p_we    = 1'b1;
                p_waddr = a_reg;
                p_wdata = (arr_sum > (TC_W+1)'(TOKEN_MAX)) ?
                          TOKEN_MAX : arr_sum[TOKEN_BITS-1:0];
            end
            ST_P_CHK: p_raddr = nl_q.place[0];
            ST_P_TOK: begin
                p_we    = (p_q != '0);
                p_waddr = ent_reg.place[0];
                p_wdata = p_q - 1'b1;
            end
            ST_T_CHK: p_raddr = nl_q.place[0];
            ST_T_PL:  p_raddr = ent_reg.place[SLOT_W'(slot_reg + 1'b1)];
            ST_T_NEXT: begin
                div_start = (e_reg == ELEM_W'(NUM_TRANSITIONS - 1)) && (cnt_reg != '0);
            end
            ST_F_ISSUE: nl_raddr = pick_reg;
            // The picked entry is still on the memory output for the first slot.
            ST_F_RD: begin
                p_raddr = (slot_reg == SLOT_W'(0)) ? nl_q.place[0] : ent_reg.place[slot_reg];
            end
            ST_F_MOD: begin
                p_we    = 1'b1;
                p_waddr = ent_reg.place[slot_reg];
                if (slot_reg < n_in) begin
                    p_wdata = (p_q == '0) ? p_q : p_q - 1'b1;
                end else begin
                    p_wdata = (p_q == TOKEN_MAX) ? p_q : p_q + 1'b1;
                end
            end
            ST_EMIT: res_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                a_reg    <= in_place[0];
                tc_reg   <= in_tc;
                rnd_reg  <= in_rnd;
                e_reg    <= ELEM_W'(NUM_TRANSITIONS);
                cnt_reg  <= '0;
                res_reg  <= '{kind: RK_ACK, last: 1'b1, default: '0};
            end
            ST_READ_DONE: res_reg.value <= 16'(p_q);
            ST_P_CHK:     ent_reg <= nl_q;
            ST_P_TOK: begin
                res_reg <= '{kind: RK_SENT, dest: 7'(ent_reg.place[1]),
                             dir: ent_reg.place[2][0], last: 1'b0, default: '0};
            end
            ST_P_NEXT: begin
                e_reg <= (e_reg == ELEM_W'(NUM_ELEMENTS - 1)) ? '0 : e_reg + 1'b1;
            end
            ST_T_CHK: begin
                ent_reg  <= nl_q;
                slot_reg <= '0;
            end
            ST_T_PL: begin
                slot_reg <= slot_reg + 1'b1;
                if (p_q != '0 && slot_reg == n_in - 1'b1) begin
                    en_list[cnt_reg[TRANS_W-1:0]] <= e_reg[TRANS_W-1:0];
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            ST_T_NEXT: begin
                e_reg <= e_reg + 1'b1;
                if (e_reg == ELEM_W'(NUM_TRANSITIONS - 1)) begin
                    res_reg <= '{kind: RK_NONE, last: 1'b1, default: '0};
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    pick_reg <= ELEM_W'(en_list[div_rem[TRANS_W-1:0]]);
                end
            end
            ST_F_RD: begin
                if (slot_reg == SLOT_W'(0)) begin
                    ent_reg <= nl_q;
                end
            end
            ST_F_ISSUE: slot_reg <= '0;
            ST_F_MOD: begin
                slot_reg <= slot_reg + 1'b1;
                res_reg  <= '{kind: RK_FIRED, fired: 6'(pick_reg),
                              count: 6'(cnt_reg), last: 1'b1, default: '0};
            end
            default: ;
        endcase
    end

    assign res = res_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(NUM_TRANSITIONS))
        else $error("enabled count beyond the transition range");
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && div_done) |-> (div_rem < cnt_reg))
        else $error("remainder not below the enabled count");
    a_fire_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_F_ISSUE) |-> (cnt_reg != '0))
        else $error("firing started with no enabled transition");
    a_emit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_reg)))
        else $error("pending result changed before transfer");
`endif

endmodule

/* rtl/petri_net_token_game_engine.sv */
`timescale 1ns / 1ps
// Top level of the Petri net token game engine: input ports, the sequencer
// and the result register. Depends on pntge_pkg and pntge_ctrl.
//
// One item is worked on at a time; a new one is taken once the previous
// item's last result has moved into the output register. A load goes
// straight to its result; an arrival first writes the summed count back and a
// read first captures the place value. A step runs through the netlist and
// place memories: a pass over the 32 port entries, with a token check for an
// output port and a result for each sending port, a scan of the 32
// transition entries, the modulo divider and the firing of a pipeline or a
// synchroniser; a stall on the result channel holds it at each result.
module petri_net_token_game_engine
    import pntge_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [5:0]  s_element_index,
    input  logic [2:0]  s_element_kind,
    input  logic [6:0]  s_place_a,
    input  logic [6:0]  s_place_b,
    input  logic [6:0]  s_place_c,
    input  logic [6:0]  s_place_d,
    input  logic [6:0]  s_place_e,
    input  logic [6:0]  s_place_f,
    input  logic [15:0] s_token_count,
    input  logic [15:0] s_random_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [6:0]  m_dest_place,
    output logic        m_direction,
    output logic [5:0]  m_fired_element,
    output logic [5:0]  m_enabled_count,
    output logic [15:0] m_token_value,
    output logic        m_last
);

    logic    res_valid, res_ready;
    result_t res;
    result_t out_reg;
    logic    m_valid_reg;
    logic [NSLOT-1:0][PLACE_W-1:0] places;

    assign places = {PLACE_W'(s_place_f), PLACE_W'(s_place_e), PLACE_W'(s_place_d),
                     PLACE_W'(s_place_c), PLACE_W'(s_place_b), PLACE_W'(s_place_a)};

    pntge_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_op     (s_op),
        .in_index  (ELEM_W'(s_element_index)),
        .in_kind   (s_element_kind),
        .in_place  (places),
        .in_tc     (s_token_count),
        .in_rnd    (s_random_value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The result register frees itself on the same cycle as its transfer.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = out_reg.kind;
    assign m_dest_place    = out_reg.dest;
    assign m_direction     = out_reg.dir;
    assign m_fired_element = out_reg.fired;
    assign m_enabled_count = out_reg.count;
    assign m_token_value   = out_reg.value;
    assign m_last          = out_reg.last;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for petri_net_token_game_engine: loads, arrivals, reads and
// steps are driven over the valid/ready input and every result transfer is compared
// with an in-bench model or a typed expectation. Depends on pntge_pkg and the engine RTL.
module tb;
    import pntge_pkg::*;

    typedef struct packed {
        logic [2:0]       op;
        logic [5:0]       idx;
        logic [2:0]       ek;
        logic [5:0][6:0]  pl;   // pl[0] is place_a
        logic [15:0]      tc;
        logic [15:0]      rv;
    } cmd_t;

    typedef struct packed {
        cmd_t    cmd;
        logic    typed;
        result_t res;
    } row_t;

    localparam logic [2:0] OP_NOP_LO = 3'd5;
    localparam logic [2:0] OP_NOP_HI = 3'd7;
    localparam logic [2:0] EK_GEN    = 3'd2;
    localparam logic [2:0] EK_SINK   = 3'd3;
    localparam int WATCHDOG_LIMIT    = 40000;
    localparam int RANDOM_ITEMS      = 120;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_op = '0;
    logic [5:0]  s_element_index = '0;
    logic [2:0]  s_element_kind = '0;
    logic [6:0]  s_place_a = '0, s_place_b = '0, s_place_c = '0;
    logic [6:0]  s_place_d = '0, s_place_e = '0, s_place_f = '0;
    logic [15:0] s_token_count = '0;
    logic [15:0] s_random_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [6:0]  m_dest_place;
    logic        m_direction;
    logic [5:0]  m_fired_element;
    logic [5:0]  m_enabled_count;
    logic [15:0] m_token_value;
    logic        m_last;

    // Mirror of the net held by the engine.
    logic [2:0]             net_kind [NUM_ELEMENTS];
    logic [5:0][6:0]        net_place [NUM_ELEMENTS];
    logic [TOKEN_BITS-1:0]  marking [NUM_PLACES];

    result_t pending_results [$];
    int      mismatches = 0;
    int      send_idle_pct = 20;
    int      recv_idle_pct = 51;
    int      quiet_cycles = 0;

    always #5 aclk = ~aclk;

    petri_net_token_game_engine i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_op(s_op), .s_element_index(s_element_index), .s_element_kind(s_element_kind),
        .s_place_a(s_place_a), .s_place_b(s_place_b), .s_place_c(s_place_c),
        .s_place_d(s_place_d), .s_place_e(s_place_e), .s_place_f(s_place_f),
        .s_token_count(s_token_count), .s_random_value(s_random_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_kind(m_kind), .m_dest_place(m_dest_place), .m_direction(m_direction),
        .m_fired_element(m_fired_element), .m_enabled_count(m_enabled_count),
        .m_token_value(m_token_value), .m_last(m_last)
    );

    function automatic result_t make_result(res_kind_t k, logic [6:0] dest, logic dir,
                                            logic [5:0] fired, logic [5:0] cnt,
                                            logic [15:0] val, logic last);
        result_t r;
        r.kind = k; r.dest = dest; r.dir = dir; r.fired = fired;
        r.count = cnt; r.value = val; r.last = last;
        return r;
    endfunction

    function automatic void take_token(logic [6:0] p);
        if (marking[p] != 0) marking[p] = marking[p] - 1'b1;
    endfunction

    function automatic void give_token(logic [6:0] p);
        if (marking[p] != TOKEN_MAX) marking[p] = marking[p] + 1'b1;
    endfunction

    // Applies one command to the mirrored net and queues the results it causes.
    function automatic void play_token_game(cmd_t c);
        logic [5:0] enabled [$];
        logic [5:0] pick;
        logic [16:0] sum;
        logic en;
        case (c.op)
            OP_LOAD_ELEM: begin
                net_kind[c.idx]  = c.ek;
                net_place[c.idx] = c.pl;
            end
            OP_LOAD_MARK: marking[c.pl[0]] = c.tc;
            OP_ARRIVE: begin
                sum = 17'(marking[c.pl[0]]) + 17'(c.tc);
                marking[c.pl[0]] = (sum > 17'(TOKEN_MAX)) ? TOKEN_MAX : sum[15:0];
            end
            OP_STEP: begin
                for (int e = NUM_TRANSITIONS; e < NUM_ELEMENTS; e++) begin
                    if (net_kind[e] == EK_PORT && marking[net_place[e][0]] != 0) begin
                        take_token(net_place[e][0]);
                        pending_results.push_back(make_result(RK_SENT, net_place[e][1],
                            net_place[e][2][0], '0, '0, '0, 1'b0));
                    end
                end
                for (int e = 0; e < NUM_TRANSITIONS; e++) begin
                    en = 1'b0;
                    if (net_kind[e] == EK_PIPE)
                        en = marking[net_place[e][0]] != 0 && marking[net_place[e][1]] != 0;
                    else if (net_kind[e] == EK_SYNC)
                        en = marking[net_place[e][0]] != 0 && marking[net_place[e][1]] != 0
                             && marking[net_place[e][2]] != 0;
                    if (en) enabled.push_back(e[5:0]);
                end
                if (enabled.size() == 0) begin
                    pending_results.push_back(make_result(RK_NONE, '0, 1'b0, '0, '0, '0, 1'b1));
                end else begin
                    pick = enabled[c.rv % enabled.size()];
                    if (net_kind[pick] == EK_PIPE) begin
                        take_token(net_place[pick][0]); take_token(net_place[pick][1]);
                        give_token(net_place[pick][2]); give_token(net_place[pick][3]);
                    end else begin
                        take_token(net_place[pick][0]); take_token(net_place[pick][1]);
                        take_token(net_place[pick][2]);
                        give_token(net_place[pick][3]); give_token(net_place[pick][4]);
                        give_token(net_place[pick][5]);
                    end
                    pending_results.push_back(make_result(RK_FIRED, '0, 1'b0, pick,
                        6'(enabled.size()), '0, 1'b1));
                end
                return;
            end
            OP_READ: begin
                pending_results.push_back(make_result(RK_ACK, '0, 1'b0, '0, '0,
                    marking[c.pl[0]], 1'b1));
                return;
            end
            default: ;
        endcase
        pending_results.push_back(make_result(RK_ACK, '0, 1'b0, '0, '0, '0, 1'b1));
    endfunction

    function automatic cmd_t make_cmd(logic [2:0] op, logic [5:0] idx, logic [2:0] ek,
                                      logic [5:0][6:0] pl, logic [15:0] tc, logic [15:0] rv);
        cmd_t c;
        c.op = op; c.idx = idx; c.ek = ek; c.pl = pl; c.tc = tc; c.rv = rv;
        return c;
    endfunction

    function automatic logic [6:0] pick_place();
        return ($urandom_range(99) < 75) ? 7'($urandom_range(7)) : 7'($urandom);
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int w;
        c.idx = 6'($urandom);
        c.rv  = 16'($urandom);
        for (int s = 0; s < 6; s++) c.pl[s] = pick_place();
        w = $urandom_range(2);
        c.ek = (w == 0) ? EK_PIPE : (w == 1) ? EK_SYNC : EK_PORT;
        if ($urandom_range(9) == 0) c.ek = 3'($urandom);
        c.tc = ($urandom_range(9) < 8) ? 16'($urandom_range(3)) : 16'($urandom);
        w = $urandom_range(99);
        if (w < 25)      c.op = OP_LOAD_ELEM;
        else if (w < 42) c.op = OP_LOAD_MARK;
        else if (w < 57) c.op = OP_ARRIVE;
        else if (w < 88) c.op = OP_STEP;
        else if (w < 97) c.op = OP_READ;
        else             c.op = 3'($urandom_range(OP_NOP_LO, OP_NOP_HI));
        return c;
    endfunction

    // Presents one command and holds it until the transfer, then predicts it.
    task automatic send_cmd(cmd_t c, logic typed, result_t typed_res);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= c.op; s_element_index <= c.idx; s_element_kind <= c.ek;
        s_place_a <= c.pl[0]; s_place_b <= c.pl[1]; s_place_c <= c.pl[2];
        s_place_d <= c.pl[3]; s_place_e <= c.pl[4]; s_place_f <= c.pl[5];
        s_token_count <= c.tc; s_random_value <= c.rv;
        do @(posedge aclk); while (!s_ready);
        play_token_game(c);
        if (typed) begin
            void'(pending_results.pop_back());
            pending_results.push_back(typed_res);
        end
    endtask

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        result_t e;
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no result outstanding");
                mismatches++;
            end else begin
                e = pending_results.pop_front();
                check_field("kind", 16'(e.kind), 16'(m_kind));
                check_field("dest_place", 16'(e.dest), 16'(m_dest_place));
                check_field("direction", 16'(e.dir), 16'(m_direction));
                check_field("fired_element", 16'(e.fired), 16'(m_fired_element));
                check_field("enabled_count", 16'(e.count), 16'(m_enabled_count));
                check_field("token_value", e.value, m_token_value);
                check_field("last", 16'(e.last), 16'(m_last));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        row_t    rows [$];
        result_t ack;
        result_t none_res;
        int      end_wait;
        ack      = make_result(RK_ACK, '0, 1'b0, '0, '0, '0, 1'b1);
        none_res = make_result(RK_NONE, '0, 1'b0, '0, '0, '0, 1'b1);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every place and netlist entry is written before anything reads it.
        for (int p = 0; p < NUM_PLACES; p++)
            send_cmd(make_cmd(OP_LOAD_MARK, '0, '0, {6{7'(p)}}, '0, '0), 1'b0, ack);
        for (int e = 0; e < NUM_ELEMENTS; e++)
            send_cmd(make_cmd(OP_LOAD_ELEM, 6'(e), EK_GEN, '0, '0, '0), 1'b1, ack);

        rows.push_back('{make_cmd(OP_STEP, '0, '0, '0, '0, 16'hFFFF), 1'b1, none_res});
        rows.push_back('{make_cmd(OP_LOAD_MARK, '0, '0, '0, 16'hFFFF, '0), 1'b1, ack});
        rows.push_back('{make_cmd(OP_ARRIVE, '0, '0, '0, 16'd1, '0), 1'b1, ack});
        rows.push_back('{make_cmd(OP_READ, '0, '0, '0, '0, '0), 1'b1,
            make_result(RK_ACK, '0, 1'b0, '0, '0, 16'hFFFF, 1'b1)});
        rows.push_back('{make_cmd(OP_ARRIVE, '0, '0, {6{7'h7F}}, 16'hFFFF, '0), 1'b1, ack});
        rows.push_back('{make_cmd(OP_READ, '0, '0, {6{7'h7F}}, '0, '0), 1'b1,
            make_result(RK_ACK, '0, 1'b0, '0, '0, 16'hFFFF, 1'b1)});
        for (logic [3:0] o = OP_NOP_LO; o <= OP_NOP_HI; o++)
            rows.push_back('{make_cmd(o[2:0], 6'h3F, 3'd7, {6{7'h7F}}, 16'hFFFF, 16'hFFFF),
                1'b1, ack});
        rows.push_back('{make_cmd(OP_LOAD_ELEM, 6'd31, EK_SINK, {6{7'h7F}}, '0, '0), 1'b1, ack});
        rows.push_back('{make_cmd(OP_LOAD_ELEM, 6'd30, 3'd7, {6{7'h7F}}, '0, '0), 1'b1, ack});
        // A pipeline whose two inputs alias, and a synchroniser next to it.
        rows.push_back('{make_cmd(OP_LOAD_MARK, '0, '0, {6{7'd1}}, 16'd1, '0), 1'b1, ack});
        rows.push_back('{make_cmd(OP_LOAD_ELEM, 6'd0, EK_PIPE,
            {7'd0, 7'd0, 7'd3, 7'd2, 7'd1, 7'd1}, '0, '0), 1'b1, ack});
        rows.push_back('{make_cmd(OP_LOAD_ELEM, 6'd1, EK_SYNC,
            {7'd5, 7'd4, 7'h7F, 7'd0, 7'd1, 7'd0}, '0, '0), 1'b1, ack});
        // Output ports at the first and last port index, one with an empty source.
        rows.push_back('{make_cmd(OP_LOAD_ELEM, 6'd32, EK_PORT,
            {7'd0, 7'd0, 7'd0, 7'd1, 7'h55, 7'd0}, '0, '0), 1'b1, ack});
        rows.push_back('{make_cmd(OP_LOAD_ELEM, 6'd63, EK_PORT,
            {7'd0, 7'd0, 7'd0, 7'd0, 7'h2A, 7'd2}, '0, '0), 1'b1, ack});
        rows.push_back('{make_cmd(OP_STEP, '0, '0, '0, '0, 16'hFFFF), 1'b0, ack});
        rows.push_back('{make_cmd(OP_STEP, '0, '0, '0, '0, 16'h0000), 1'b0, ack});
        rows.push_back('{make_cmd(OP_ARRIVE, '0, '0, {6{7'd1}}, 16'd5, '0), 1'b1, ack});
        rows.push_back('{make_cmd(OP_STEP, '0, '0, '0, '0, 16'h8001), 1'b0, ack});
        rows.push_back('{make_cmd(OP_READ, '0, '0, {6{7'd3}}, '0, '0), 1'b0, ack});

        foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].typed, rows[i].res);

        // The sender holds off until the engine has drained completely.
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct = 51; recv_idle_pct = 20;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            send_cmd(random_cmd(), 1'b0, ack);
        end
        s_valid <= 1'b0;

        end_wait = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        while (end_wait < 400) begin
            @(posedge aclk);
            end_wait++;
        end
        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
rtl/pntge_pkg.sv
rtl/pntge_divider.sv
rtl/pntge_ctrl.sv
rtl/petri_net_token_game_engine.sv
bench/tb.sv
